// File: rtl/ckc_pkg.sv
`default_nettype none
package ckc_pkg;

    // fixed field widths
    localparam int unsigned KMER_W    = 62;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned LEN_W     = 5;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned INDEX_W   = 12;
    localparam int unsigned USED_W    = 13;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned S_DATA_W  = 24;
    localparam int unsigned M_DATA_W  = 112;
    localparam int unsigned APB_W     = 32;
    localparam int unsigned PADDR_W   = 3;

    // defaults and limits
    localparam int unsigned DEF_TABLE_ENTRIES = 4096;
    localparam int unsigned DEF_MAX_KMER_LEN  = 31;
    localparam logic [LEN_W-1:0]   BASES_SAT    = 5'd31;
    localparam logic [LEN_W-1:0]   K_SIZE_RST   = 5'd21;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

    // register indexes
    localparam logic REG_K_SIZE     = 1'b0;
    localparam logic REG_CNT_THRESH = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_BASE  = 2'd0,
        OP_EOR   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD,
        S_CMP,
        S_UPD,
        S_INSERT,
        S_RDONE,
        S_FIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_start;
        logic ptr_inc;
        logic rd_idx;
        logic upd;
        logic insert;
        logic rdout;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic clean;
        logic used_zero;
        logic idx_ok;
        logic hit;
        logic last;
        logic out_free;
    } t_stat;

    // 2-bit base code, valid flag in the top bit
    function automatic logic [2:0] base_code(input logic [CHAR_W-1:0] c);
        logic [2:0] r;
        case (c)
            8'h41:   r = 3'b100;
            8'h43:   r = 3'b101;
            8'h47:   r = 3'b110;
            8'h54:   r = 3'b111;
            default: r = 3'b000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ckc_ram.sv
`default_nettype none
module ckc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// File: rtl/ckc_ctrl.sv
`default_nettype none
module ckc_ctrl
    import ckc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);
    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_BASE: begin
                        if (!i_stat.clean) begin
                            n_state = S_FIN;
                        end else if (i_stat.used_zero) begin
                            n_state = S_INSERT;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_RD;
                        end
                    end
                    OP_READ: begin
                        if (i_stat.idx_ok) begin
                            o_cmd.rd_idx = 1'b1;
                            n_state      = S_RDONE;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                if (i_stat.hit) begin
                    n_state = S_UPD;
                end else if (i_stat.last) begin
                    n_state = S_INSERT;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_FIN;
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_FIN;
            end
            S_RDONE: begin
                o_cmd.rdout = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/ckc_dp.sv
`default_nettype none
module ckc_dp
    import ckc_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int unsigned MAX_KMER_LEN  = DEF_MAX_KMER_LEN
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [OP_W-1:0]       i_op,
    input  wire logic [CHAR_W-1:0]     i_char,
    input  wire logic [INDEX_W-1:0]    i_idx,
    input  wire logic [LEN_W-1:0]      i_k_size,
    input  wire logic [COUNT_W-1:0]    i_cnt_thresh,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    output logic                       o_m_valid,
    input  wire logic                  i_m_ready,
    output logic [M_DATA_W-1:0]        o_m_data
);
    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned IW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int unsigned RW = KMER_W + COUNT_W;
    localparam logic [LEN_W-1:0] KMAX = LEN_W'(MAX_KMER_LEN);

    t_op                r_op;
    logic [IW-1:0]      r_idx;
    logic [KMER_W-1:0]  r_fwd, r_rev, r_canon;
    logic [LEN_W-1:0]   r_bases, r_bad;
    logic [CW-1:0]      r_used;
    logic [AW-1:0]      r_ptr;
    logic               r_counted, r_dropped, r_report;
    logic [KMER_W-1:0]  r_kmer;
    logic [COUNT_W-1:0] r_count;
    logic               r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;

    logic [LEN_W-1:0]   k;
    logic [2:0]         code;
    logic [1:0]         fc, rc;
    logic [KMER_W-1:0]  mask, n_fwd, n_rev;
    logic [LEN_W-1:0]   n_bases, n_bad;
    logic               full;
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [RW-1:0]      ram_wdata, ram_rdata;
    logic [KMER_W-1:0]  rd_key;
    logic [COUNT_W-1:0] rd_cnt, inc_cnt;

    // effective length and new window contents
    always_comb begin
        k = i_k_size;
        if (k == '0) k = LEN_W'(1);
        if (k > KMAX) k = KMAX;
        code  = base_code(i_char);
        fc    = code[1:0];
        rc    = code[2] ? ~code[1:0] : 2'b00;
        mask  = ~({KMER_W{1'b1}} << {k, 1'b0});
        n_fwd = ({r_fwd[KMER_W-3:0], fc}) & mask;
        n_rev = ((r_rev >> 2) | (KMER_W'(rc) << {k - LEN_W'(1), 1'b0})) & mask;
        n_bases = (r_bases < BASES_SAT) ? r_bases + LEN_W'(1) : r_bases;
        if (!code[2]) begin
            n_bad = k;
        end else if (r_bad != '0) begin
            n_bad = r_bad - LEN_W'(1);
        end else begin
            n_bad = r_bad;
        end
    end

    assign full   = (r_used == CW'(TABLE_ENTRIES));
    assign rd_key = ram_rdata[RW-1:COUNT_W];
    assign rd_cnt = ram_rdata[COUNT_W-1:0];
    assign inc_cnt = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_W'(1);

    // read state, windows and count of entries in use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd   <= '0;
            r_rev   <= '0;
            r_bases <= '0;
            r_bad   <= '0;
            r_used  <= '0;
        end else begin
            if (i_cmd.load) begin
                case (t_op'(i_op))
                    OP_BASE: begin
                        r_fwd   <= n_fwd;
                        r_rev   <= n_rev;
                        r_bases <= n_bases;
                        r_bad   <= n_bad;
                    end
                    OP_EOR: begin
                        r_fwd   <= '0;
                        r_rev   <= '0;
                        r_bases <= '0;
                        r_bad   <= '0;
                    end
                    OP_CLEAR: r_used <= '0;
                    default: ;
                endcase
            end
            if (i_cmd.insert && !full) begin
                r_used <= r_used + CW'(1);
            end
        end
    end

    // item latch, canonical form, scan pointer, result
    always_ff @(posedge i_clk) begin
        r_canon <= (r_fwd < r_rev) ? r_fwd : r_rev;
        if (i_cmd.load) begin
            r_op      <= t_op'(i_op);
            r_idx     <= IW'(i_idx);
            r_counted <= 1'b0;
            r_dropped <= 1'b0;
            r_report  <= 1'b0;
            r_kmer    <= '0;
            r_count   <= '0;
        end
        if (i_cmd.scan_start) begin
            r_ptr <= '0;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + AW'(1);
        end
        if (i_cmd.upd) begin
            r_counted <= 1'b1;
            r_kmer    <= r_canon;
            r_count   <= inc_cnt;
        end
        if (i_cmd.insert) begin
            r_kmer <= r_canon;
            if (full) begin
                r_dropped <= 1'b1;
            end else begin
                r_counted <= 1'b1;
                r_count   <= COUNT_W'(1);
            end
        end
        if (i_cmd.rdout) begin
            r_kmer   <= rd_key;
            r_count  <= rd_cnt;
            r_report <= (rd_cnt > i_cnt_thresh);
        end
    end

    // table memory port
    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = {r_canon, inc_cnt};
        if (i_cmd.rd_idx) begin
            ram_addr = AW'(r_idx);
        end else if (i_cmd.insert) begin
            ram_addr = AW'(r_used);
        end else begin
            ram_addr = r_ptr;
        end
        if (i_cmd.upd) begin
            ram_we = 1'b1;
        end else if (i_cmd.insert && !full) begin
            ram_we    = 1'b1;
            ram_wdata = {r_canon, COUNT_W'(1)};
        end
    end

    ckc_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // status to controller
    always_comb begin
        o_stat.op        = r_op;
        o_stat.clean     = (r_bad == '0) && (r_bases >= k);
        o_stat.used_zero = (r_used == '0);
        o_stat.idx_ok    = (r_idx < IW'(r_used));
        o_stat.hit       = (rd_key == r_canon);
        o_stat.last      = ((CW'(r_ptr) + CW'(1)) == r_used);
        o_stat.out_free  = !r_m_valid || i_m_ready;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_data <= {1'b0, full, USED_W'(r_used), r_report, r_count, r_kmer,
                         r_dropped, r_counted};
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;
endmodule
`default_nettype wire

// File: rtl/canonical_kmer_counter.sv
// Canonical k-mer counter. Feed one word per item on the slave stream: tuser carries the
// opcode (base, end of read, read out entry, clear table); every item yields exactly one
// result word. A base item whose window is not counted goes from decode to the result;
// otherwise the entries in use (at most TABLE_ENTRIES) are searched one at a time: the
// table lives in one single-port memory with registered read (address, then compare).
// Read-out reads the entry only when its index is in use; end of read and clear go
// straight to the result. A result that still waits on the master side holds the next
// one back until it is taken. A new item is taken while the previous result is still
// waiting on the master side. The user must write the k-mer length and the report
// threshold over the APB port only while the block is idle; the block does not enforce it.
`default_nettype none
module canonical_kmer_counter
    import ckc_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int unsigned MAX_KMER_LEN  = DEF_MAX_KMER_LEN
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [7:0] base_char, [19:8] entry_index, [23:20] zero
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // [1:0] opcode
    input  wire logic [OP_W-1:0]     s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [0] kmer_counted, [1] dropped, [63:2] kmer, [95:64] count, [96] report,
    // [109:97] entries_used, [110] table_full, [111] zero
    output logic [M_DATA_W-1:0]      m_tdata,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [APB_W-1:0]    pwdata,
    output logic [APB_W-1:0]         prdata,
    output logic                     pready
);
    logic [LEN_W-1:0]   r_k_size;
    logic [COUNT_W-1:0] r_cnt_thresh;
    t_cmd               cmd;
    t_stat              stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_size     <= K_SIZE_RST;
            r_cnt_thresh <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_K_SIZE:     r_k_size     <= pwdata[LEN_W-1:0];
                REG_CNT_THRESH: r_cnt_thresh <= pwdata;
                default: ;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CNT_THRESH) ? r_cnt_thresh : APB_W'(r_k_size);

    ckc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ckc_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_KMER_LEN  (MAX_KMER_LEN)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (s_tuser),
        .i_char       (s_tdata[CHAR_W-1:0]),
        .i_idx        (s_tdata[CHAR_W+INDEX_W-1:CHAR_W]),
        .i_k_size     (r_k_size),
        .i_cnt_thresh (r_cnt_thresh),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_m_valid    (m_tvalid),
        .i_m_ready    (m_tready),
        .o_m_data     (m_tdata)
    );

    // a word is never both counted and dropped
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("counted and dropped together");

    // a read-out report never comes with a count update
    a_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[96]) |-> !m_tdata[0])
        else $error("report on a base word");

    // one item at a time: after an accept the input side closes
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while busy");
endmodule
`default_nettype wire
